/* rtl/kll_pkg.sv */
// Package for the kernel language lexer: token codes, scan modes and the
// token record passed from the front scanner to the back emitter.
// No dependencies.
package kll_pkg;

  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_SLASH   = 4'd1,
    M_LINE    = 4'd2,
    M_BLOCK   = 4'd3,
    M_BSTAR   = 4'd4,
    M_INT     = 4'd5,
    M_INTDOT  = 4'd6,
    M_FRAC    = 4'd7,
    M_WORD    = 4'd8,
    M_WORDDOT = 4'd9,
    M_OP      = 4'd10
  } mode_e;

  localparam logic [5:0] T_END     = 6'd0;
  localparam logic [5:0] T_IDENT   = 6'd1;
  localparam logic [5:0] T_INT     = 6'd2;
  localparam logic [5:0] T_FLOAT   = 6'd3;
  localparam logic [5:0] T_BUILTIN = 6'd12;
  localparam logic [5:0] T_SLASH   = 6'd23;
  localparam logic [5:0] T_UNKNOWN = 6'd43;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [23:0] offset;
    logic [7:0]  length;
  } token_t;

  // Up to three tokens produced by one item, in order.
  typedef struct packed {
    logic [1:0] count;
    token_t     t0;
    token_t     t1;
    token_t     t2;
  } bundle_t;

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == 8'h20 || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic [5:0] op_single(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      8'h3d:   k = 6'd33;
      8'h21:   k = 6'd35;
      8'h3c:   k = 6'd37;
      8'h3e:   k = 6'd39;
      default: k = T_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] b);
    logic [5:0] k;
    case (b)
      8'h2b:   k = 6'd21;
      8'h2d:   k = 6'd22;
      8'h28:   k = 6'd24;
      8'h29:   k = 6'd25;
      8'h7b:   k = 6'd26;
      8'h7d:   k = 6'd27;
      8'h5b:   k = 6'd28;
      8'h5d:   k = 6'd29;
      8'h3b:   k = 6'd30;
      8'h2c:   k = 6'd31;
      8'h2a:   k = 6'd32;
      default: k = T_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

/* rtl/kll_front.sv */
// Front scanner of the kernel language lexer: consumes one byte per item,
// tracks position and scan mode, and produces a bundle of up to three tokens.
// Depends on kll_pkg.
module kll_front #(
  parameter int MAX_WORD_MATCH = 9,
  parameter int OFFSET_BITS    = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          source_byte_i,
  input  logic                end_of_source_i,
  output logic                bnd_valid_o,
  input  logic                bnd_stall_i,
  output kll_pkg::bundle_t    bnd_o
);
  import kll_pkg::*;

  localparam int WIDX = $clog2(MAX_WORD_MATCH);

  mode_e                  mode_q, mode_d;
  logic [7:0]             word_q [MAX_WORD_MATCH];
  logic [7:0]             pend_op_q, pend_op_d;
  logic [7:0]             len_q, len_d;
  logic [15:0]            sline_q, sline_d, scol_q, scol_d;
  logic [OFFSET_BITS-1:0] soff_q, soff_d;
  logic [15:0]            line_q, line_d, col_q, col_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic                   wr_en;
  logic [WIDX-1:0]        wr_idx;
  logic                   bv_q;
  bundle_t                b_q, b_d;
  logic                   acc;

  logic [5:0]             wkind;
  logic [1:0]             bgrp;
  logic                   bvalid;

  assign in_stall_o  = bv_q && bnd_stall_i;
  assign acc         = in_valid_i && !in_stall_o;
  assign bnd_valid_o = bv_q;
  assign bnd_o       = b_q;

  function automatic logic wmatch(input logic [7:0] w [MAX_WORD_MATCH],
                                  input logic [7:0] l,
                                  input logic [8*9-1:0] s,
                                  input int n);
    logic ok;
    ok = (l == 8'(n));
    for (int i = 0; i < 9; i++) begin
      if (i < n && w[i] != s[8*(8-i) +: 8]) ok = 1'b0;
    end
    return ok;
  endfunction

  always_comb begin
    wkind = T_IDENT;
    if (wmatch(word_q, len_q, {"kernel", 24'h0}, 6)) wkind = 6'd4;
    if (wmatch(word_q, len_q, {"void", 40'h0}, 4))   wkind = 6'd5;
    if (wmatch(word_q, len_q, {"int", 48'h0}, 3))    wkind = 6'd6;
    if (wmatch(word_q, len_q, {"float", 32'h0}, 5))  wkind = 6'd7;
    if (wmatch(word_q, len_q, {"if", 56'h0}, 2))     wkind = 6'd8;
    if (wmatch(word_q, len_q, {"else", 40'h0}, 4))   wkind = 6'd9;
    if (wmatch(word_q, len_q, {"for", 48'h0}, 3))    wkind = 6'd10;
    if (wmatch(word_q, len_q, {"return", 24'h0}, 6)) wkind = 6'd11;
    bvalid = 1'b1;
    bgrp   = 2'd0;
    if (wmatch(word_q, len_q, "threadIdx", 9))            bgrp = 2'd0;
    else if (wmatch(word_q, len_q, {"blockIdx", 8'h0}, 8)) bgrp = 2'd1;
    else if (wmatch(word_q, len_q, {"blockDim", 8'h0}, 8)) bgrp = 2'd2;
    else bvalid = 1'b0;
  end

  always_comb begin
    logic [7:0]             b;
    logic                   held;
    logic [15:0]            cl, cc;
    logic [OFFSET_BITS-1:0] co;
    logic [8:0]             l1, l2;
    token_t                 t;
    token_t                 q [3];
    logic [1:0]             n;
    logic [7:0]             plen;

    b = source_byte_i;
    held = 1'b0;
    mode_d = mode_q; pend_op_d = pend_op_q; len_d = len_q;
    sline_d = sline_q; scol_d = scol_q; soff_d = soff_q;
    cl = line_q; cc = col_q; co = off_q;
    wr_en = 1'b0; wr_idx = '0;
    n = 2'd0;
    q[0] = '0; q[1] = '0; q[2] = '0;
    t = '0;
    plen = len_q;
    l1 = {1'b0, len_q} + 9'd1;
    l2 = {1'b0, len_q} + 9'd2;

    if (end_of_source_i) begin
      t.line = sline_q; t.column = scol_q; t.offset = 24'(soff_q); t.length = len_q;
      unique case (mode_q)
        M_SLASH: begin t.kind = T_SLASH; t.length = 8'd1; q[n] = t; n = n + 2'd1; end
        M_INT:   begin t.kind = T_INT;   q[n] = t; n = n + 2'd1; end
        M_FRAC:  begin t.kind = T_FLOAT; q[n] = t; n = n + 2'd1; end
        M_WORD:  begin t.kind = wkind;   q[n] = t; n = n + 2'd1; end
        M_OP: begin
          t.kind = op_single(pend_op_q); t.length = 8'd1; q[n] = t; n = n + 2'd1;
        end
        M_INTDOT, M_WORDDOT: begin
          t.kind = (mode_q == M_INTDOT) ? T_INT : wkind;
          q[n] = t; n = n + 2'd1;
          q[n] = '{kind: T_UNKNOWN, line: cl, column: cc, offset: 24'(co), length: 8'd1};
          n = n + 2'd1;
          co = co + 1'b1;
          if (cc != 16'hffff) cc = cc + 16'd1;
        end
        default: ;
      endcase
      q[n] = '{kind: T_END, line: cl, column: cc, offset: 24'(co), length: 8'd0};
      n = n + 2'd1;
      mode_d = M_IDLE; pend_op_d = '0; len_d = '0;
      sline_d = 16'd1; scol_d = 16'd1; soff_d = '0;
      cl = 16'd1; cc = 16'd1; co = '0;
    end else begin
      logic go_idle;
      logic emit_pend;
      logic [5:0] pkind;
      logic extra_unk;
      logic dot_adv;
      go_idle = 1'b0; emit_pend = 1'b0; pkind = T_INT; extra_unk = 1'b0; dot_adv = 1'b0;
      unique case (mode_q)
        M_IDLE: go_idle = 1'b1;
        M_SLASH: begin
          if (b == 8'h2f) mode_d = M_LINE;
          else if (b == 8'h2a) mode_d = M_BLOCK;
          else begin emit_pend = 1'b1; pkind = T_SLASH; plen = 8'd1; go_idle = 1'b1; end
        end
        M_LINE:  if (b == 8'h0a) mode_d = M_IDLE;
        M_BLOCK: if (b == 8'h2a) mode_d = M_BSTAR;
        M_BSTAR: begin
          if (b == 8'h2f) mode_d = M_IDLE;
          else if (b != 8'h2a) mode_d = M_BLOCK;
        end
        M_INT, M_FRAC: begin
          if (is_digit(b)) len_d = l1[8] ? 8'hff : l1[7:0];
          else if (b == 8'h2e && mode_q == M_INT) begin mode_d = M_INTDOT; held = 1'b1; end
          else if (b == 8'h66 || b == 8'h46) begin
            emit_pend = 1'b1; pkind = T_FLOAT; mode_d = M_IDLE;
          end else begin
            emit_pend = 1'b1; pkind = (mode_q == M_INT) ? T_INT : T_FLOAT; go_idle = 1'b1;
          end
        end
        M_INTDOT: begin
          dot_adv = 1'b1;
          if (is_digit(b)) begin
            len_d = l2[8] ? 8'hff : l2[7:0]; mode_d = M_FRAC;
          end else begin
            emit_pend = 1'b1; pkind = T_INT; extra_unk = 1'b1; go_idle = 1'b1;
          end
        end
        M_WORD: begin
          if (is_alpha(b) || is_digit(b) || b == 8'h5f) begin
            if (len_q < 8'(MAX_WORD_MATCH)) begin
              wr_en = 1'b1; wr_idx = len_q[WIDX-1:0];
            end
            len_d = l1[8] ? 8'hff : l1[7:0];
          end else if (b == 8'h2e && bvalid) begin
            mode_d = M_WORDDOT; held = 1'b1;
          end else begin
            emit_pend = 1'b1; pkind = wkind; go_idle = 1'b1;
          end
        end
        M_WORDDOT: begin
          dot_adv = 1'b1;
          if (bvalid && (b == 8'h78 || b == 8'h79 || b == 8'h7a)) begin
            emit_pend = 1'b1;
            pkind = T_BUILTIN + 6'(bgrp) * 6'd3 + 6'(b - 8'h78);
            plen = l2[8] ? 8'hff : l2[7:0];
            mode_d = M_IDLE;
          end else begin
            emit_pend = 1'b1; pkind = wkind; extra_unk = 1'b1; go_idle = 1'b1;
          end
        end
        M_OP: begin
          logic pm;
          logic [5:0] pk;
          pm = 1'b0; pk = T_UNKNOWN;
          case (pend_op_q)
            8'h3d: begin pk = 6'd34; pm = (b == 8'h3d); end
            8'h21: begin pk = 6'd36; pm = (b == 8'h3d); end
            8'h3c: begin pk = 6'd38; pm = (b == 8'h3d); end
            8'h3e: begin pk = 6'd40; pm = (b == 8'h3d); end
            8'h26: begin pk = 6'd41; pm = (b == 8'h26); end
            8'h7c: begin pk = 6'd42; pm = (b == 8'h7c); end
            default: ;
          endcase
          emit_pend = 1'b1; plen = pm ? 8'd2 : 8'd1;
          if (pm) begin pkind = pk; mode_d = M_IDLE; end
          else begin pkind = op_single(pend_op_q); go_idle = 1'b1; end
        end
        default: go_idle = 1'b1;
      endcase
      if (emit_pend) begin
        q[n] = '{kind: pkind, line: sline_q, column: scol_q, offset: 24'(soff_q),
                 length: plen};
        n = n + 2'd1;
      end
      if (extra_unk) begin
        q[n] = '{kind: T_UNKNOWN, line: cl, column: cc, offset: 24'(co), length: 8'd1};
        n = n + 2'd1;
      end
      if (dot_adv) begin
        co = co + 1'b1;
        if (cc != 16'hffff) cc = cc + 16'd1;
      end
      if (go_idle) begin
        mode_d = M_IDLE;
        if (!is_space(b)) begin
          if (is_digit(b) || is_alpha(b) || b == 8'h5f || b == 8'h2f ||
              b == 8'h3d || b == 8'h21 || b == 8'h3c || b == 8'h3e ||
              b == 8'h26 || b == 8'h7c) begin
            sline_d = cl; scol_d = cc; soff_d = co; len_d = 8'd1;
            if (is_digit(b)) mode_d = M_INT;
            else if (b == 8'h2f) mode_d = M_SLASH;
            else if (is_alpha(b) || b == 8'h5f) begin
              mode_d = M_WORD; wr_en = 1'b1; wr_idx = '0;
            end else begin
              mode_d = M_OP; pend_op_d = b;
            end
          end else begin
            q[n] = '{kind: single_kind(b), line: cl, column: cc, offset: 24'(co),
                     length: 8'd1};
            n = n + 2'd1;
          end
        end
      end
      if (!held) begin
        co = co + 1'b1;
        if (b == 8'h0a) begin
          if (cl != 16'hffff) cl = cl + 16'd1;
          cc = 16'd1;
        end else if (cc != 16'hffff) cc = cc + 16'd1;
      end
    end
    line_d = cl; col_d = cc; off_d = co;
    b_d.count = n; b_d.t0 = q[0]; b_d.t1 = q[1]; b_d.t2 = q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; pend_op_q <= '0; len_q <= '0;
      sline_q <= 16'd1; scol_q <= 16'd1; soff_q <= '0;
      line_q <= 16'd1; col_q <= 16'd1; off_q <= '0;
      bv_q <= 1'b0;
    end else begin
      if (acc) begin
        mode_q <= mode_d; pend_op_q <= pend_op_d; len_q <= len_d;
        sline_q <= sline_d; scol_q <= scol_d; soff_q <= soff_d;
        line_q <= line_d; col_q <= col_d; off_q <= off_d;
        bv_q <= (b_d.count != 2'd0);
      end else if (!bnd_stall_i) begin
        bv_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) b_q <= b_d;
    if (acc && wr_en) word_q[wr_idx] <= source_byte_i;
  end

endmodule

/* rtl/kll_back.sv */
// Back emitter of the kernel language lexer: a two-entry bundle queue and an
// unpacker delivering one token per cycle unless stalled. Depends on kll_pkg.
module kll_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             bnd_valid_i,
  output logic             bnd_stall_o,
  input  kll_pkg::bundle_t bnd_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [5:0]       token_kind_o,
  output logic [15:0]      start_line_o,
  output logic [15:0]      start_column_o,
  output logic [23:0]      start_offset_o,
  output logic [7:0]       text_length_o,
  output logic             last_of_run_o
);
  import kll_pkg::*;

  bundle_t    fifo_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic [1:0] idx_q;
  bundle_t    head;
  token_t     tok;
  logic       push, pop, fire, last;

  assign head        = fifo_q[rp_q];
  assign bnd_stall_o = (cnt_q == 2'd2);
  assign push        = bnd_valid_i && !bnd_stall_o;
  assign out_valid_o = (cnt_q != 2'd0);
  assign fire        = out_valid_o && !out_stall_i;
  assign last        = ({1'b0, idx_q} + 3'd1) == {1'b0, head.count};
  assign pop         = fire && last;

  always_comb begin
    case (idx_q)
      2'd0:    tok = head.t0;
      2'd1:    tok = head.t1;
      default: tok = head.t2;
    endcase
  end

  assign token_kind_o   = tok.kind;
  assign start_line_o   = tok.line;
  assign start_column_o = tok.column;
  assign start_offset_o = tok.offset;
  assign text_length_o  = tok.length;
  assign last_of_run_o  = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0; idx_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
      if (pop) idx_q <= 2'd0;
      else if (fire) idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= bnd_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("bundle queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> head.count != 2'd0)
    else $error("empty bundle in queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> idx_q < head.count)
    else $error("token index past bundle");

endmodule

/* rtl/kernel_language_lexer.sv */
// Top level of the kernel language lexer: front scanner, bundle queue and
// token emitter. Depends on kll_pkg, kll_front and kll_back.
//
//  channel | direction | handshake          | payload
//  input   | in        | in_valid_i/stall_o | source_byte_i, end_of_source_i
//  output  | out       | out_valid_o/stall_i| token fields, last_of_run_o
//
// One source byte enters and one token leaves per cycle unless stalled.
// An item of two or three tokens holds the emitter until each has left.
// An item's first token passes the front's bundle register, then the queue.
// Reset is asynchronous, active low, and returns the lexer to line 1, column 1.
// Output stall backs up through the two-entry queue into the input stall.
module kernel_language_lexer #(
  parameter int MAX_WORD_MATCH = 9,
  parameter int OFFSET_BITS    = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  source_byte_i,
  input  logic        end_of_source_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  token_kind_o,
  output logic [15:0] start_line_o,
  output logic [15:0] start_column_o,
  output logic [23:0] start_offset_o,
  output logic [7:0]  text_length_o,
  output logic        last_of_run_o
);
  import kll_pkg::*;

  bundle_t bnd;
  logic    bnd_valid, bnd_stall;

  kll_front #(.MAX_WORD_MATCH(MAX_WORD_MATCH), .OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .source_byte_i, .end_of_source_i,
    .bnd_valid_o(bnd_valid), .bnd_stall_i(bnd_stall), .bnd_o(bnd)
  );

  kll_back u_back (
    .clk_i, .rst_ni, .bnd_valid_i(bnd_valid), .bnd_stall_o(bnd_stall), .bnd_i(bnd),
    .out_valid_o, .out_stall_i, .token_kind_o, .start_line_o, .start_column_o,
    .start_offset_o, .text_length_o, .last_of_run_o
  );

endmodule

/* dv/kernel_language_lexer_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for kernel_language_lexer: byte streams in, tokens out,
// compared against an in-bench lexer model. Depends on kll_pkg and the lexer RTL.
module kernel_language_lexer_tb;
  import kll_pkg::*;

  localparam int LIMIT = 1000000;
  localparam int WORD_KEEP = 9;

  localparam logic [5:0] K_KERNEL = 6'd4, K_VOID = 6'd5, K_INTKW = 6'd6, K_FLOATKW = 6'd7;
  localparam logic [5:0] K_IF = 6'd8, K_ELSE = 6'd9, K_FOR = 6'd10, K_RETURN = 6'd11;
  localparam logic [5:0] K_PLUS = 6'd21, K_MINUS = 6'd22, K_LPAR = 6'd24, K_RPAR = 6'd25;
  localparam logic [5:0] K_LBRACE = 6'd26, K_RBRACE = 6'd27, K_LBRACK = 6'd28;
  localparam logic [5:0] K_RBRACK = 6'd29, K_SEMI = 6'd30, K_COMMA = 6'd31, K_STAR = 6'd32;
  localparam logic [5:0] K_ASSIGN = 6'd33, K_EQ = 6'd34, K_NOT = 6'd35, K_NE = 6'd36;
  localparam logic [5:0] K_LT = 6'd37, K_LE = 6'd38, K_GT = 6'd39, K_GE = 6'd40;
  localparam logic [5:0] K_AND = 6'd41, K_OR = 6'd42;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [23:0] offset;
    logic [7:0]  length;
    logic        last;
  } tok_s;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  source_byte_i = '0;
  logic        end_of_source_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [5:0]  token_kind_o;
  logic [15:0] start_line_o;
  logic [15:0] start_column_o;
  logic [23:0] start_offset_o;
  logic [7:0]  text_length_o;
  logic        last_of_run_o;

  kernel_language_lexer dut (.*);

  always #5 clk_i = ~clk_i;

  mode_e       scan;
  logic [7:0]  prefix [WORD_KEEP];
  logic [7:0]  pend_op;
  logic [7:0]  tlen;
  logic [15:0] tline, tcol, cline, ccol;
  logic [23:0] toff, coff;
  tok_s        run_q[$];
  tok_s        token_q[$];

  int  errors = 0;
  int  cycles = 0;
  int  hold_cycles = 0;
  int  stall_run = 0;
  bit  gaps_on = 1'b1;
  bit  stalls_on = 1'b1;

  function automatic bit c_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit c_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit c_word(logic [7:0] b);
    return c_alpha(b) || c_digit(b) || b == "_";
  endfunction

  function automatic bit c_space(logic [7:0] b);
    return b == " " || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic [7:0] grown(int n);
    return (int'(tlen) + n > 255) ? 8'd255 : 8'(int'(tlen) + n);
  endfunction

  function automatic void lexer_clear();
    scan = M_IDLE;
    foreach (prefix[i]) prefix[i] = '0;
    pend_op = '0;
    tlen = '0;
    tline = 16'd1;
    tcol = 16'd1;
    toff = '0;
    cline = 16'd1;
    ccol = 16'd1;
    coff = '0;
  endfunction

  function automatic void step_pos(logic [7:0] b);
    coff = coff + 24'd1;
    if (b == 8'h0a) begin
      if (cline != 16'hffff) cline = cline + 16'd1;
      ccol = 16'd1;
    end else if (ccol != 16'hffff) begin
      ccol = ccol + 16'd1;
    end
  endfunction

  function automatic void put_tok(logic [5:0] k, logic [15:0] l, logic [15:0] c,
                                  logic [23:0] o, logic [7:0] n);
    tok_s t;
    t = '{k, l, c, o, n, 1'b0};
    if (run_q.size() < 3) run_q.insert(run_q.size(), t);
  endfunction

  function automatic void put_pending(logic [5:0] k, logic [7:0] n);
    put_tok(k, tline, tcol, toff, n);
  endfunction

  function automatic void put_here(logic [5:0] k, logic [7:0] n);
    put_tok(k, cline, ccol, coff, n);
  endfunction

  function automatic bit word_eq(string s);
    if (int'(tlen) != s.len() || s.len() > WORD_KEEP) return 1'b0;
    for (int i = 0; i < s.len(); i++) if (prefix[i] != s[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int index_group();
    if (word_eq("threadIdx")) return 0;
    if (word_eq("blockIdx")) return 1;
    if (word_eq("blockDim")) return 2;
    return -1;
  endfunction

  function automatic logic [5:0] word_class();
    if (word_eq("kernel")) return K_KERNEL;
    if (word_eq("void")) return K_VOID;
    if (word_eq("int")) return K_INTKW;
    if (word_eq("float")) return K_FLOATKW;
    if (word_eq("if")) return K_IF;
    if (word_eq("else")) return K_ELSE;
    if (word_eq("for")) return K_FOR;
    if (word_eq("return")) return K_RETURN;
    return T_IDENT;
  endfunction

  function automatic logic [5:0] lone_op(logic [7:0] c);
    case (c)
      "=":     return K_ASSIGN;
      "!":     return K_NOT;
      "<":     return K_LT;
      ">":     return K_GT;
      default: return T_UNKNOWN;
    endcase
  endfunction

  function automatic bit pair_op(logic [7:0] c, logic [7:0] b, output logic [5:0] k);
    k = T_UNKNOWN;
    case (c)
      "=": begin k = K_EQ; return b == "="; end
      "!": begin k = K_NE; return b == "="; end
      "<": begin k = K_LE; return b == "="; end
      ">": begin k = K_GE; return b == "="; end
      "&": begin k = K_AND; return b == "&"; end
      "|": begin k = K_OR; return b == "|"; end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void open_tok(logic [7:0] n);
    tline = cline;
    tcol = ccol;
    toff = coff;
    tlen = n;
  endfunction

  function automatic void between_tokens(logic [7:0] b);
    scan = M_IDLE;
    if (c_space(b)) return;
    if (c_digit(b)) begin
      open_tok(8'd1);
      scan = M_INT;
      return;
    end
    if (c_alpha(b) || b == "_") begin
      open_tok(8'd1);
      prefix[0] = b;
      scan = M_WORD;
      return;
    end
    case (b)
      "/": begin open_tok(8'd1); scan = M_SLASH; end
      "=", "!", "<", ">", "&", "|": begin open_tok(8'd1); pend_op = b; scan = M_OP; end
      "+": put_here(K_PLUS, 8'd1);
      "-": put_here(K_MINUS, 8'd1);
      "(": put_here(K_LPAR, 8'd1);
      ")": put_here(K_RPAR, 8'd1);
      "{": put_here(K_LBRACE, 8'd1);
      "}": put_here(K_RBRACE, 8'd1);
      "[": put_here(K_LBRACK, 8'd1);
      "]": put_here(K_RBRACK, 8'd1);
      ";": put_here(K_SEMI, 8'd1);
      ",": put_here(K_COMMA, 8'd1);
      "*": put_here(K_STAR, 8'd1);
      default: put_here(T_UNKNOWN, 8'd1);
    endcase
  endfunction

  function automatic void flush_open();
    case (scan)
      M_SLASH: put_pending(T_SLASH, 8'd1);
      M_INT: put_pending(T_INT, tlen);
      M_FRAC: put_pending(T_FLOAT, tlen);
      M_INTDOT: begin
        put_pending(T_INT, tlen);
        put_here(T_UNKNOWN, 8'd1);
        step_pos(".");
      end
      M_WORD: put_pending(word_class(), tlen);
      M_WORDDOT: begin
        put_pending(word_class(), tlen);
        put_here(T_UNKNOWN, 8'd1);
        step_pos(".");
      end
      M_OP: put_pending(lone_op(pend_op), 8'd1);
      default: ;
    endcase
  endfunction

  function automatic void lex_byte(logic [7:0] b, logic eos);
    bit         held;
    logic [5:0] k;
    int         g;
    held = 1'b0;
    run_q.delete();
    if (eos) begin
      flush_open();
      put_here(T_END, 8'd0);
      lexer_clear();
    end else begin
      case (scan)
        M_IDLE: between_tokens(b);
        M_SLASH: begin
          if (b == "/") scan = M_LINE;
          else if (b == "*") scan = M_BLOCK;
          else begin put_pending(T_SLASH, 8'd1); between_tokens(b); end
        end
        M_LINE: if (b == 8'h0a) scan = M_IDLE;
        M_BLOCK: if (b == "*") scan = M_BSTAR;
        M_BSTAR: begin
          if (b == "/") scan = M_IDLE;
          else if (b != "*") scan = M_BLOCK;
        end
        M_INT, M_FRAC: begin
          if (c_digit(b)) tlen = grown(1);
          else if (b == "." && scan == M_INT) begin scan = M_INTDOT; held = 1'b1; end
          else if (b == "f" || b == "F") begin put_pending(T_FLOAT, tlen); scan = M_IDLE; end
          else begin
            put_pending(scan == M_INT ? T_INT : T_FLOAT, tlen);
            between_tokens(b);
          end
        end
        M_INTDOT: begin
          if (c_digit(b)) begin
            step_pos(".");
            tlen = grown(2);
            scan = M_FRAC;
          end else begin
            put_pending(T_INT, tlen);
            put_here(T_UNKNOWN, 8'd1);
            step_pos(".");
            between_tokens(b);
          end
        end
        M_WORD: begin
          if (c_word(b)) begin
            if (tlen < WORD_KEEP) prefix[tlen] = b;
            tlen = grown(1);
          end else if (b == "." && index_group() >= 0) begin
            scan = M_WORDDOT;
            held = 1'b1;
          end else begin
            put_pending(word_class(), tlen);
            between_tokens(b);
          end
        end
        M_WORDDOT: begin
          g = index_group();
          if (g >= 0 && (b == "x" || b == "y" || b == "z")) begin
            step_pos(".");
            put_pending(6'(int'(T_BUILTIN) + 3 * g + int'(b - 8'h78)), grown(2));
            scan = M_IDLE;
          end else begin
            put_pending(word_class(), tlen);
            put_here(T_UNKNOWN, 8'd1);
            step_pos(".");
            between_tokens(b);
          end
        end
        M_OP: begin
          if (pair_op(pend_op, b, k)) begin put_pending(k, 8'd2); scan = M_IDLE; end
          else begin put_pending(lone_op(pend_op), 8'd1); between_tokens(b); end
        end
        default: between_tokens(b);
      endcase
      if (!held) step_pos(b);
    end
    if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
    foreach (run_q[i]) token_q.insert(token_q.size(), run_q[i]);
  endfunction

  task automatic send_byte(logic [7:0] b, logic eos);
    in_valid_i <= 1'b1;
    source_byte_i <= b;
    end_of_source_i <= eos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    lex_byte(b, eos);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      source_byte_i <= 8'($urandom);
      end_of_source_i <= 1'($urandom);
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(15, 40) : $urandom_range(1, 3))
        @(posedge clk_i);
    end
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    tok_s got, want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{token_kind_o, start_line_o, start_column_o, start_offset_o,
                text_length_o, last_of_run_o};
        if (token_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected token kind=%0d", $time, token_kind_o);
        end else begin
          want = token_q.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected kind=%0d line=%0d col=%0d off=%0d len=%0d last=%0d",
                     $time, want.kind, want.line, want.column, want.offset, want.length,
                     want.last);
            $display("%0t:          actual kind=%0d line=%0d col=%0d off=%0d len=%0d last=%0d",
                     $time, got.kind, got.line, got.column, got.offset, got.length, got.last);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_cycles > 0) begin
        hold_cycles = hold_cycles - 1;
        out_stall_i <= 1'b1;
      end else if (stall_run > 0) begin
        stall_run = stall_run - 1;
        out_stall_i <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic test_directed();
    send_text("threadIdx.y 1.5f 2.x a.z<=/**/&|");
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b1);
    send_text("blockDim.");
    send_byte(8'h00, 1'b1);
    send_text("9.");
    send_byte(8'hff, 1'b1);
    send_text("/*");
    send_byte(8'h00, 1'b1);
    send_text("=");
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_saturation();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    for (int i = 0; i < 256; i++) send_byte("7", 1'b0);
    send_text(" abcdefghijklmnop; threadIdxx.x");
    send_byte(8'h00, 1'b1);
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic test_random();
    string pieces[] = '{"kernel", "void", "int", "float", "if", "else", "for", "return",
      "threadIdx.x", "threadIdx.z", "blockIdx.y", "blockDim.z", "blockDim.w", "blockIdx",
      "foo_1", "_a9", "12", "3.25", "7f", "4.5F", "9.", "0.1.", "+", "-", "/", "(", ")",
      "{", "}", "[", "]", ";", ",", "*", "=", "==", "!", "!=", "<", "<=", ">", ">=",
      "&&", "||", "&", "|", "// note\n", "/* a * b **/", "@", ".", "\t", "\n"};
    int sent;
    int r;
    sent = 0;
    while (sent < 20) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        send_byte(8'($urandom), 1'b1);
        sent++;
      end else if (r < 3) begin
        send_byte(8'($urandom), 1'b0);
        sent++;
      end else begin
        r = $urandom_range(0, pieces.size() - 1);
        send_text(pieces[r]);
        sent += pieces[r].len();
        if ($urandom_range(0, 1) == 0) begin
          send_byte($urandom_range(0, 1) ? " " : 8'h0a, 1'b0);
          sent++;
        end
      end
    end
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    gaps_on = 1'b0;
    for (int i = 0; i < 8; i++) send_text("a+ ");
    send_byte(8'h00, 1'b1);
    gaps_on = 1'b1;
  endtask

  initial begin
    lexer_clear();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random();
    test_saturation();
    in_valid_i <= 1'b0;
    while (token_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
